[design/pwt_pkg.sv]
// shared types and constants of the phrase word tokenizer
package pwt_pkg;

    // result kinds
    localparam logic [1:0] KIND_LETTER     = 2'd0;
    localparam logic [1:0] KIND_WORD_END   = 2'd1;
    localparam logic [1:0] KIND_PHRASE_END = 2'd2;

    // a word shorter than this many letters plus one is dropped
    localparam logic [1:0] SHORT_LIMIT = 2'd2;

    // results one input item can cause
    localparam int MAX_RESULTS = 3;

    // input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       flush;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [6:0] letter;
        logic [1:0] kind;
        logic       last;
    } t_out_item;

    // one result inside a job
    typedef struct packed {
        logic [6:0] letter;
        logic [1:0] kind;
    } t_slot;

    // all results caused by one input item, slot 0 first
    typedef struct packed {
        logic [1:0]                    cnt;
        t_slot [MAX_RESULTS-1:0]       slot;
    } t_job;

endpackage

[design/pwt_front.sv]
// front part: classifies each byte, keeps word state and builds a job for each item that causes results
module pwt_front
    import pwt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_job_valid,
    output t_job     o_job
);

    logic [6:0] r_held [2];
    logic [6:0] n_held [2];
    logic [1:0] r_word_len;
    logic [1:0] n_word_len;
    logic       r_phrase_open;
    logic       n_phrase_open;

    logic       is_upper;
    logic       is_lower;
    logic       is_letter;
    logic       is_soft;
    logic [6:0] low_char;
    logic       word_kept;
    logic       phrase_after;
    t_job       job;

    // byte classification and case folding
    always_comb begin
        is_upper  = (i_item.text_byte >= 8'd65) && (i_item.text_byte <= 8'd90);
        is_lower  = (i_item.text_byte >= 8'd97) && (i_item.text_byte <= 8'd122);
        is_letter = is_upper || is_lower;
        is_soft   = (i_item.text_byte == 8'd32) || (i_item.text_byte == 8'd45);
        low_char  = is_upper ? (i_item.text_byte[6:0] + 7'd32) : i_item.text_byte[6:0];
    end

    // next state and job contents
    always_comb begin
        n_held        = r_held;
        n_word_len    = r_word_len;
        n_phrase_open = r_phrase_open;
        word_kept     = (r_word_len > SHORT_LIMIT);
        phrase_after  = r_phrase_open || word_kept;
        job           = '0;

        if (i_item.flush) begin
            // close word and phrase, then back to reset values
            job.cnt          = {1'b0, word_kept} + {1'b0, phrase_after};
            job.slot[0].kind = word_kept ? KIND_WORD_END : KIND_PHRASE_END;
            job.slot[1].kind = KIND_PHRASE_END;
            n_held[0]        = '0;
            n_held[1]        = '0;
            n_word_len       = '0;
            n_phrase_open    = 1'b0;
        end else if (is_letter) begin
            if (r_word_len < SHORT_LIMIT) begin
                n_held[r_word_len[0]] = low_char;
                n_word_len            = r_word_len + 2'd1;
            end else if (r_word_len == SHORT_LIMIT) begin
                // third letter releases the held pair
                job.cnt            = 2'd3;
                job.slot[0].letter = r_held[0];
                job.slot[1].letter = r_held[1];
                job.slot[2].letter = low_char;
                n_word_len         = 2'd3;
            end else begin
                job.cnt            = 2'd1;
                job.slot[0].letter = low_char;
            end
        end else if (is_soft) begin
            job.cnt          = {1'b0, word_kept};
            job.slot[0].kind = KIND_WORD_END;
            n_word_len       = '0;
            n_phrase_open    = phrase_after;
        end else begin
            job.cnt          = {1'b0, word_kept} + {1'b0, phrase_after};
            job.slot[0].kind = word_kept ? KIND_WORD_END : KIND_PHRASE_END;
            job.slot[1].kind = KIND_PHRASE_END;
            n_word_len       = '0;
            n_phrase_open    = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held[0]     <= '0;
            r_held[1]     <= '0;
            r_word_len    <= '0;
            r_phrase_open <= 1'b0;
        end else if (i_accept) begin
            r_held        <= n_held;
            r_word_len    <= n_word_len;
            r_phrase_open <= n_phrase_open;
        end
    end

    assign o_job_valid = i_accept && (job.cnt != 2'd0);
    assign o_job       = job;

    // a flush leaves no open word or phrase
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.flush) |=> (r_word_len == 2'd0 && !r_phrase_open))
        else $error("flush did not clear word state");

    // third letter saturates the word length
    a_third_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_item.flush && is_letter && r_word_len == SHORT_LIMIT)
        |=> (r_word_len == 2'd3))
        else $error("word length did not reach three");

    // a phrase-ending byte always closes the phrase
    a_hard_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_item.flush && !is_letter && !is_soft) |=> !r_phrase_open)
        else $error("phrase still open after phrase-ending byte");

endmodule

[design/pwt_fifo.sv]
// short job queue between the front and the back part
module pwt_fifo
    import pwt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);

    localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

    t_job            r_mem [DEPTH];
    logic [IdxW-1:0] r_wr_idx;
    logic [IdxW-1:0] r_rd_idx;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_idx];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_idx] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_idx <= (r_wr_idx == LastIdx) ? '0 : r_wr_idx + 1'b1;
            end
            if (do_pop) begin
                r_rd_idx <= (r_rd_idx == LastIdx) ? '0 : r_rd_idx + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/pwt_back.sv]
// back part: plays each job out one result per cycle while i_pop is high
module pwt_back
    import pwt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_empty,
    input  t_job      i_job,
    output logic      o_job_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       at_last;
    logic       out_xfer;
    logic       load;

    assign at_last   = (r_idx == (r_job.cnt - 2'd1));
    assign out_xfer  = i_pop && r_busy;
    assign load      = (!r_busy || (out_xfer && at_last)) && !i_job_empty;
    assign o_job_pop = load;
    assign o_empty   = !r_busy;

    // current result
    always_comb begin
        o_item.letter = r_job.slot[r_idx].letter;
        o_item.kind   = r_job.slot[r_idx].kind;
        o_item.last   = at_last;
    end

    // job register and result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_xfer) begin
            if (at_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

    // a held job never is empty
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_job.cnt != 2'd0))
        else $error("empty job in back part");

    // index stays inside the job
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_job.cnt))
        else $error("result index beyond job");

    // a transfer that is not last leaves more of the same job
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !at_last) |=> (r_busy && r_idx == $past(r_idx) + 2'd1))
        else $error("job cut short");

endmodule

[design/phrase_word_tokenizer.sv]
// top level of the phrase word tokenizer
//
// Input channel: a queue write port. An item (text byte and flush flag) is
// transferred on a rising edge with push high and full low. Result channel:
// a queue read port. While empty is low the oldest result (letter, kind, last)
// is on o_out_item; it is transferred on a rising edge with pop high.
// Each input byte causes zero to three results; last marks the final one.
// With nothing waiting ahead, a result passes through the job queue and the job
// register of the back part before it is on the output.
// Throughput: one item per cycle while full is low; full stays low while each
// item causes at most one result and pop is held high. Results leave at one per
// cycle while pop is high, set by the single job register of the back part.
// A front part classifies bytes and updates the word state at transfer time,
// a job queue of QUEUE_DEPTH entries holds the results of each item, and a
// back part plays them out. When the receiver stalls the queue fills and full
// rises; items causing no result are taken even then only if full is low.
// Reset (synchronous, active low) clears word state, queue and output.
module phrase_word_tokenizer
    import pwt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_in_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    logic accept;
    logic job_valid;
    t_job front_job;
    t_job queue_job;
    logic queue_empty;
    logic queue_pop;

    assign accept = push && !full;

    // classification and word state
    pwt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_job_valid (job_valid),
        .o_job       (front_job)
    );

    // job queue
    pwt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_data  (queue_job)
    );

    // result sequencing
    pwt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (queue_empty),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule
